// File: rtl/assert_macros.svh
// Assertion macros used by the evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i, suspended while rst_ni is low.
`define PSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, also during reset.
`define PSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/pse_pkg.sv
// Shared constants and types of the postfix stack evaluator.
`default_nettype none

package pse_pkg;

  localparam int unsigned StackDepth = 512;
  localparam int unsigned LevelW     = $clog2(StackDepth + 1);
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned DataW      = 32;
  localparam int unsigned SymW       = 8;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned CntW       = $clog2(DataW);

  // ASCII codes of the characters the evaluator acts on.
  localparam logic [SymW-1:0] SymPlus  = 8'h2B;
  localparam logic [SymW-1:0] SymMinus = 8'h2D;
  localparam logic [SymW-1:0] SymStar  = 8'h2A;
  localparam logic [SymW-1:0] SymSlash = 8'h2F;
  localparam logic [SymW-1:0] SymTilde = 8'h7E;
  localparam logic [SymW-1:0] SymOne   = 8'h31;
  localparam logic [SymW-1:0] SymNine  = 8'h39;
  localparam logic [SymW-1:0] SymZero  = 8'h30;

  // Result status codes.
  localparam logic [StatusW-1:0] StOk      = 2'd0;
  localparam logic [StatusW-1:0] StDivZero = 2'd1;
  localparam logic [StatusW-1:0] StFault   = 2'd2;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] result;
  } alu_rsp_t;

endpackage

`default_nettype wire

// File: rtl/pse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module pse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/pse_alu.sv
// Arithmetic unit: add and subtract straight from the operands, bit-serial multiply and divide.
`default_nettype none

module pse_alu (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pse_pkg::alu_req_t           req_i,
  input  wire logic [pse_pkg::DataW-1:0]   opa_i,
  input  wire logic [pse_pkg::DataW-1:0]   opb_i,
  output pse_pkg::alu_rsp_t                rsp_o
);

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhLoop = 2'd1;
  localparam logic [1:0] PhFix  = 2'd2;

  logic [1:0]                 phase_q, phase_d;
  logic                       done_q, done_d;
  pse_pkg::alu_op_e           op_q, op_d;
  logic [pse_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [pse_pkg::DataW-1:0]  acc_q, acc_d;
  logic [pse_pkg::DataW-1:0]  mcand_q, mcand_d;
  logic [pse_pkg::DataW-1:0]  mplier_q, mplier_d;
  logic [pse_pkg::DataW-1:0]  res_q, res_d;
  logic                       neg_q, neg_d;

  logic [pse_pkg::DataW-1:0]  mag_a, mag_b, rem_sh;
  logic [pse_pkg::DataW:0]    diff;

  // Magnitudes of the signed operands for the divider.
  assign mag_a  = opa_i[pse_pkg::DataW-1] ? (~opa_i + 1'b1) : opa_i;
  assign mag_b  = opb_i[pse_pkg::DataW-1] ? (~opb_i + 1'b1) : opb_i;
  // One restoring-division step: shift in the next dividend bit, try to subtract.
  assign rem_sh = {acc_q[pse_pkg::DataW-2:0], mplier_q[pse_pkg::DataW-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, mcand_q};

  always_comb begin
    phase_d  = phase_q;
    done_d   = 1'b0;
    op_d     = op_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    res_d    = res_q;
    neg_d    = neg_q;
    unique case (phase_q)
      PhIdle: begin
        if (req_i.start) begin
          op_d  = req_i.op;
          cnt_d = '0;
          acc_d = '0;
          unique case (req_i.op)
            pse_pkg::ALU_ADD: begin
              res_d  = opa_i + opb_i;
              done_d = 1'b1;
            end
            pse_pkg::ALU_SUB: begin
              res_d  = opa_i - opb_i;
              done_d = 1'b1;
            end
            pse_pkg::ALU_MUL: begin
              mcand_d  = opa_i;
              mplier_d = opb_i;
              phase_d  = PhLoop;
            end
            pse_pkg::ALU_DIV: begin
              mcand_d  = mag_b;
              mplier_d = mag_a;
              neg_d    = opa_i[pse_pkg::DataW-1] ^ opb_i[pse_pkg::DataW-1];
              phase_d  = PhLoop;
            end
            default: phase_d = PhIdle;
          endcase
        end
      end
      PhLoop: begin
        if (op_q == pse_pkg::ALU_DIV) begin
          if (!diff[pse_pkg::DataW]) begin
            acc_d = diff[pse_pkg::DataW-1:0];
          end else begin
            acc_d = rem_sh;
          end
          mplier_d = {mplier_q[pse_pkg::DataW-2:0], ~diff[pse_pkg::DataW]};
        end else begin
          if (mplier_q[0]) begin
            acc_d = acc_q + mcand_q;
          end
          mcand_d  = {mcand_q[pse_pkg::DataW-2:0], 1'b0};
          mplier_d = {1'b0, mplier_q[pse_pkg::DataW-1:1]};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == pse_pkg::CntW'(pse_pkg::DataW - 1)) begin
          phase_d = PhFix;
        end
      end
      PhFix: begin
        if (op_q == pse_pkg::ALU_DIV) begin
          res_d = neg_q ? (~mplier_q + 1'b1) : mplier_q;
        end else begin
          res_d = acc_q;
        end
        done_d  = 1'b1;
        phase_d = PhIdle;
      end
      default: phase_d = PhIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    cnt_q    <= cnt_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    res_q    <= res_d;
    neg_q    <= neg_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

`default_nettype wire

// File: rtl/postfix_stack_evaluator.sv
// Top level of the postfix expression evaluator with its operand stack control.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i / in_stall_o    symbol_i[7:0], last_i
// out      output     out_valid_o / out_stall_i  value_o[31:0] signed, status_o[1:0]
//
// A digit, a negation or an ignored character is handled in the accept cycle. Addition and
// subtraction pass through the accept cycle, the stack read and the write-back.
// Multiplication and division wait in the run state for the ALU, which
// resolves one multiplier or quotient bit per cycle over 32 steps.
// A character marked last leads to the emit state, which loads the result
// register and waits there while a previous result is still stalled at the output.
// Reset clears the stack level, the fault code and all handshake state; the
// stack memory itself needs no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module postfix_stack_evaluator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [pse_pkg::SymW-1:0]      symbol_i,
  input  wire logic                          last_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [pse_pkg::DataW-1:0]   value_o,
  output logic [pse_pkg::StatusW-1:0]        status_o
);

  // Control sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [pse_pkg::LevelW-1:0]    level_q, level_d;
  logic [pse_pkg::StatusW-1:0]   fault_q, fault_d;
  logic                          last_q, last_d;
  pse_pkg::alu_op_e              op_q, op_d;
  logic [pse_pkg::DataW-1:0]     top_q, top_d;
  logic                          out_valid_q, out_valid_d;
  logic [pse_pkg::DataW-1:0]     value_q, value_d;
  logic [pse_pkg::StatusW-1:0]   status_q, status_d;

  logic                          accept;
  logic                          is_digit, is_tilde, is_binop, is_div;
  logic                          level_full, level_empty, level_lt2, top_zero;
  logic                          out_free;
  logic [pse_pkg::LevelW-1:0]    level_m1, level_m2;
  logic                          ram_we, ram_re;
  logic [pse_pkg::DataW-1:0]     ram_rdata;
  pse_pkg::alu_req_t             alu_req;
  pse_pkg::alu_rsp_t             alu_rsp;
  pse_pkg::alu_op_e              sym_op;
  logic [pse_pkg::StatusW-1:0]   final_status;

  // Items are taken only while the sequencer waits for a character.
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Character decode.
  assign is_digit = (symbol_i >= pse_pkg::SymOne) && (symbol_i <= pse_pkg::SymNine);
  assign is_tilde = (symbol_i == pse_pkg::SymTilde);
  assign is_div   = (symbol_i == pse_pkg::SymSlash);
  assign is_binop = (symbol_i == pse_pkg::SymPlus) || (symbol_i == pse_pkg::SymMinus) ||
                    (symbol_i == pse_pkg::SymStar) || is_div;

  always_comb begin
    priority if (symbol_i == pse_pkg::SymPlus) begin
      sym_op = pse_pkg::ALU_ADD;
    end else if (symbol_i == pse_pkg::SymMinus) begin
      sym_op = pse_pkg::ALU_SUB;
    end else if (symbol_i == pse_pkg::SymStar) begin
      sym_op = pse_pkg::ALU_MUL;
    end else begin
      sym_op = pse_pkg::ALU_DIV;
    end
  end

  // The top of the stack lives in top_q; the memory holds the entries below
  // it, so entry k of the stack sits at address k while it is not the top.
  assign level_full  = (level_q == pse_pkg::LevelW'(pse_pkg::StackDepth));
  assign level_empty = (level_q == '0);
  assign level_lt2   = (level_q < pse_pkg::LevelW'(2));
  assign top_zero    = (top_q == '0);
  assign level_m1    = level_q - pse_pkg::LevelW'(1);
  assign level_m2    = level_q - pse_pkg::LevelW'(2);

  // A push spills the old top to memory; a binary operator reads the entry
  // just below the top, which the registered read delivers in S_FETCH.
  assign ram_we = accept && (fault_q == pse_pkg::StOk) && is_digit &&
                  !level_full && !level_empty;
  assign ram_re = accept && (fault_q == pse_pkg::StOk) && is_binop &&
                  !(is_div && !level_empty && top_zero) && !level_lt2;

  pse_ram #(
    .Width (pse_pkg::DataW),
    .Depth (pse_pkg::StackDepth)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (level_m1[pse_pkg::AddrW-1:0]),
    .wdata_i (top_q),
    .re_i    (ram_re),
    .raddr_i (level_m2[pse_pkg::AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // The lower entry is the left operand, the top the right one.
  assign alu_req.start = (state_q == S_FETCH);
  assign alu_req.op    = op_q;

  pse_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .opa_i  (ram_rdata),
    .opb_i  (top_q),
    .rsp_o  (alu_rsp)
  );

  // A pending fault wins; otherwise an empty stack at the end is a stack fault.
  always_comb begin
    if (fault_q != pse_pkg::StOk) begin
      final_status = fault_q;
    end else if (level_empty) begin
      final_status = pse_pkg::StFault;
    end else begin
      final_status = pse_pkg::StOk;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    fault_d     = fault_q;
    last_d      = last_q;
    op_d        = op_q;
    top_d       = top_q;
    value_d     = value_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          last_d  = last_i;
          op_d    = sym_op;
          state_d = last_i ? S_EMIT : S_IDLE;
          // After a fault the rest of the expression is only scanned for its end.
          if (fault_q == pse_pkg::StOk) begin
            if (is_digit) begin
              if (level_full) begin
                fault_d = pse_pkg::StFault;
              end else begin
                top_d   = {{(pse_pkg::DataW - 4){1'b0}}, symbol_i[3:0]};
                level_d = level_q + pse_pkg::LevelW'(1);
              end
            end else if (is_tilde) begin
              if (level_empty) begin
                fault_d = pse_pkg::StFault;
              end else begin
                top_d = ~top_q + 1'b1;
              end
            end else if (is_binop) begin
              // The divisor is checked before the operand count.
              if (is_div && !level_empty && top_zero) begin
                fault_d = pse_pkg::StDivZero;
              end else if (level_lt2) begin
                fault_d = pse_pkg::StFault;
              end else begin
                state_d = S_FETCH;
              end
            end
          end
        end
      end
      S_FETCH: begin
        state_d = S_RUN;
      end
      S_RUN: begin
        if (alu_rsp.done) begin
          top_d   = alu_rsp.result;
          level_d = level_q - pse_pkg::LevelW'(1);
          state_d = last_q ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = final_status;
          value_d     = (final_status == pse_pkg::StOk) ? top_q : '0;
          level_d     = '0;
          fault_d     = pse_pkg::StOk;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      level_q     <= '0;
      fault_q     <= pse_pkg::StOk;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      fault_q     <= fault_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q   <= last_d;
    op_q     <= op_d;
    top_q    <= top_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = $signed(value_q);
  assign status_o    = status_q;

  // The stack level never passes the stack depth.
  `PSE_ASSERT(a_level_bound, level_q <= pse_pkg::LevelW'(pse_pkg::StackDepth), "stack level beyond depth")
  // The ALU only reports a result while the sequencer waits for it.
  `PSE_ASSERT(a_alu_done_in_run, alu_rsp.done |-> (state_q == S_RUN), "ALU result outside run state")
  // Emitting a result clears the stack and the fault for the next expression.
  `PSE_ASSERT(a_emit_clears, (state_q == S_EMIT) && out_free |=> out_valid_q && (level_q == '0) && (fault_q == pse_pkg::StOk), "result emit did not clear stack")
  // A faulted result carries a zero value.
  `PSE_ASSERT(a_fault_zero, out_valid_q && (status_q != pse_pkg::StOk) |-> (value_q == '0), "nonzero value with fault status")

endmodule

`default_nettype wire

// File: tb/postfix_stack_evaluator_tb.sv
// Self-checking testbench of the postfix stack evaluator with its own expression predictor.
`timescale 1ns / 1ps

module postfix_stack_evaluator_tb;
  import pse_pkg::*;

  // Run limits.
  localparam int unsigned CycleLimit     = 3_000_000;
  localparam int unsigned InputItems     = 1700;
  localparam int unsigned DrainCycles    = 80;
  localparam int unsigned LongHoldAfter  = 40;
  localparam int unsigned LongHoldCycles = 2000;
  localparam int unsigned PauseEvery     = 60;

  // Characters that the evaluator ignores, used as filler.
  localparam logic [SymW-1:0] SymSpace   = 8'h20;
  localparam logic [SymW-1:0] SymLetterA = 8'h61;
  localparam logic [SymW-1:0] SymLetterZ = 8'h7A;

  localparam logic signed [DataW-1:0] MostNegative = 32'sh8000_0000;

  typedef struct {
    logic [SymW-1:0] symbol;
    logic            last;
    bit              pause_first;
  } pending_symbol_t;

  typedef struct {
    logic signed [DataW-1:0] value;
    logic [StatusW-1:0]      status;
  } eval_result_t;

  typedef logic [SymW-1:0] symbol_q_t[$];

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Every block input holds a known value from time zero.
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [SymW-1:0]         symbol = '0;
  logic                    last = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [DataW-1:0] value;
  logic [StatusW-1:0]      status;

  postfix_stack_evaluator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .symbol_i   (symbol),
    .last_i     (last),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .value_o    (value),
    .status_o   (status)
  );

  always #1 clk_i = ~clk_i;

  // Symbols waiting to be offered, and results that the predictor has worked out
  // but the block has not yet delivered.
  pending_symbol_t pending_symbols[$];
  eval_result_t    expected_results[$];
  symbol_q_t       expr_buf;

  // Predictor state: its own operand stack, fill level and fault code.
  logic signed [DataW-1:0] eval_stack [StackDepth];
  int unsigned             eval_depth = 0;
  logic [StatusW-1:0]      eval_fault = StOk;

  int unsigned failures = 0;
  int unsigned symbols_sent = 0;
  int unsigned results_checked = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};
  int unsigned deepest_stack = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned longest_output_hold = 0;
  int unsigned cycle_count = 0;

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  // One character applied to the predicted stack. Digits push, operators pop two and
  // push one, negation rewrites the top, and anything else leaves the state alone.
  function automatic void step_symbol(input logic [SymW-1:0] c);
    logic signed [DataW-1:0] lhs, rhs, res;
    if (c >= SymOne && c <= SymNine) begin
      if (eval_depth >= StackDepth) begin
        eval_fault = StFault;
      end else begin
        eval_stack[eval_depth] = DataW'(c - SymZero);
        eval_depth++;
        if (eval_depth > deepest_stack) deepest_stack = eval_depth;
      end
    end else if (c == SymTilde) begin
      if (eval_depth < 1) eval_fault = StFault;
      else eval_stack[eval_depth - 1] = -eval_stack[eval_depth - 1];
    end else if (c == SymPlus || c == SymMinus || c == SymStar || c == SymSlash) begin
      // The divisor is looked at before the operand count, so a lone zero divides by zero.
      if (c == SymSlash && eval_depth >= 1 && eval_stack[eval_depth - 1] == '0) begin
        eval_fault = StDivZero;
      end else if (eval_depth < 2) begin
        eval_fault = StFault;
      end else begin
        rhs = eval_stack[eval_depth - 1];
        lhs = eval_stack[eval_depth - 2];
        case (c)
          SymPlus:  res = lhs + rhs;
          SymMinus: res = lhs - rhs;
          SymStar:  res = lhs * rhs;
          // Truncating division; the one overflowing quotient wraps back to itself.
          default:  res = (lhs == MostNegative && rhs == -1) ? lhs : lhs / rhs;
        endcase
        eval_depth--;
        eval_stack[eval_depth - 1] = res;
      end
    end
  endfunction

  // Called for every accepted input transfer. Once faulted, the rest of the
  // expression is skipped; the last character closes the expression and queues its result.
  function automatic void predict_transfer(input logic [SymW-1:0] c, input logic lst);
    eval_result_t res;
    if (eval_fault == StOk) step_symbol(c);
    if (lst) begin
      res.value  = '0;
      res.status = eval_fault;
      if (eval_fault == StOk) begin
        if (eval_depth == 0) res.status = StFault;
        else res.value = eval_stack[eval_depth - 1];
      end
      expected_results.push_back(res);
      status_seen[res.status]++;
      eval_depth = 0;
      eval_fault = StOk;
    end
  endfunction

  // Idle lengths: mostly none or short, now and then a long one. A calm phase
  // gives a stretch without any idling.
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [SymW-1:0] dig(input int unsigned d);
    return SymZero + SymW'(d);
  endfunction

  // Multiplication and division are weighted up so that values reach the full range.
  function automatic logic [SymW-1:0] pick_operator();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 32) return SymStar;
    if (r < 52) return SymPlus;
    if (r < 74) return SymMinus;
    return SymSlash;
  endfunction

  function automatic logic [SymW-1:0] pick_ignored();
    int unsigned r;
    r = $urandom_range(0, 2);
    if (r == 0) return SymZero;
    if (r == 1) return SymSpace;
    return SymW'($urandom_range(SymLetterA, SymLetterZ));
  endfunction

  // Moves the expression in expr_buf to the send queue with the final character
  // marked last. A pause makes the sender wait until every result is back.
  task automatic queue_expr(input bit pause_first);
    pending_symbol_t item;
    foreach (expr_buf[i]) begin
      item.symbol      = expr_buf[i];
      item.last        = (i == expr_buf.size() - 1);
      item.pause_first = pause_first && (i == 0);
      pending_symbols.push_back(item);
    end
    expr_buf.delete();
  endtask

  // Appends a well-formed expression with the given number of binary operators,
  // with negations and ignored characters sprinkled in.
  task automatic build_valid(input int unsigned binops);
    int unsigned digits_left, ops_left, depth;
    digits_left = binops + 1;
    ops_left    = binops;
    depth       = 0;
    while (digits_left + ops_left > 0) begin
      if (depth >= 2 && ops_left > 0 && (digits_left == 0 || $urandom_range(0, 1) == 1)) begin
        expr_buf.push_back(pick_operator());
        ops_left--;
        depth--;
      end else begin
        expr_buf.push_back(dig($urandom_range(1, 9)));
        digits_left--;
        depth++;
      end
      if (depth >= 1 && $urandom_range(0, 7) == 0) expr_buf.push_back(SymTilde);
      if ($urandom_range(0, 19) == 0) expr_buf.push_back(pick_ignored());
    end
  endtask

  // Pushes 2^31 as a product of eleven factors; it wraps to the most negative value.
  task automatic put_most_negative();
    expr_buf.push_back(dig(2));
    expr_buf.push_back(dig(8));
    repeat (9) begin
      expr_buf.push_back(dig(8));
      expr_buf.push_back(SymStar);
    end
    expr_buf.push_back(SymStar);
  endtask

  // Driver. A new symbol is put on the bus only when the previous one has been
  // transferred or the bus is idle, so a stalled symbol never changes.
  always @(posedge clk_i or negedge rst_ni) begin : drive_symbols
    pending_symbol_t next_item;
    int unsigned     send_gap;
    bit              send_calm;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      symbol    <= '0;
      last      <= 1'b0;
      send_gap  = 0;
      send_calm = 1'b0;
    end else begin
      if (in_valid && in_stall) input_stall_cycles++;
      if (in_valid && !in_stall) begin
        predict_transfer(symbol, last);
        symbols_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_symbols.size() > 0 &&
                     !(pending_symbols[0].pause_first && expected_results.size() > 0)) begin
          next_item = pending_symbols.pop_front();
          in_valid <= 1'b1;
          symbol   <= next_item.symbol;
          last     <= next_item.last;
          if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
          send_gap = pick_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall. Besides the random stalls it holds off once for a long
  // stretch, so that results back up and the block has to stall its input.
  always @(posedge clk_i or negedge rst_ni) begin : drive_out_stall
    int unsigned stall_left, hold_run;
    bit          long_hold_done, stall_calm;
    if (!rst_ni) begin
      out_stall      <= 1'b0;
      stall_left     = 0;
      hold_run       = 0;
      long_hold_done = 1'b0;
      stall_calm     = 1'b0;
    end else begin
      hold_run = out_stall ? hold_run + 1 : 0;
      if (hold_run > longest_output_hold) longest_output_hold = hold_run;
      if (!long_hold_done && results_checked >= LongHoldAfter) begin
        long_hold_done = 1'b1;
        stall_left     = LongHoldCycles - 1;
        out_stall     <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        if ($urandom_range(0, 299) == 0) stall_calm = !stall_calm;
        stall_left = ($urandom_range(0, 99) < 35) ? pick_gap(stall_calm) : 0;
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Monitor. Each result transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    eval_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result: value %0d status %0d", value, status));
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (value !== want.value || status !== want.status)
          note_failure($sformatf("result %0d: expected value %0d status %0d, got value %0d status %0d",
                                 results_checked, want.value, want.status, value, status));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_results.size());
      $display("postfix_stack_evaluator regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned expr_count, kind, n;

    // Directed expressions: each operator, truncating division of a negative
    // value, ignored characters, leftover entries, and each way of faulting.
    expr_buf = '{dig(9), dig(8), SymPlus};                 queue_expr(1'b0);
    expr_buf = '{dig(1), dig(3), SymMinus};                queue_expr(1'b0);
    expr_buf = '{dig(4), dig(6), SymStar};                 queue_expr(1'b0);
    expr_buf = '{dig(7), SymTilde, dig(2), SymSlash};      queue_expr(1'b0);
    expr_buf = '{dig(2), SymSpace, dig(5), dig(7)};        queue_expr(1'b0);
    expr_buf = '{SymZero};                                 queue_expr(1'b0);
    expr_buf = '{SymTilde};                                queue_expr(1'b0);
    expr_buf = '{dig(5), SymPlus};                         queue_expr(1'b0);
    expr_buf = '{dig(1), dig(1), SymMinus, SymSlash};      queue_expr(1'b0);
    expr_buf = '{dig(4), dig(1), dig(1), SymMinus, SymSlash, dig(2), SymPlus};
    queue_expr(1'b0);

    // Extreme values: the most negative value, its overflowing quotient by
    // minus one, and the most positive value one step below it.
    put_most_negative();                                   queue_expr(1'b1);
    put_most_negative();
    expr_buf.push_back(dig(1));
    expr_buf.push_back(SymTilde);
    expr_buf.push_back(SymSlash);
    queue_expr(1'b0);
    put_most_negative();
    expr_buf.push_back(dig(1));
    expr_buf.push_back(SymMinus);
    queue_expr(1'b0);

    // A completely full stack is fine; one more digit overflows it.
    repeat (StackDepth) expr_buf.push_back(dig($urandom_range(1, 9)));
    expr_buf.push_back(SymPlus);
    queue_expr(1'b0);
    repeat (StackDepth + 1) expr_buf.push_back(dig($urandom_range(1, 9)));
    queue_expr(1'b0);

    // Random part: mostly well-formed expressions, some noise and some broken
    // ones, until the whole run holds about the planned number of symbols.
    // Every so often the sender waits until every result has come back.
    expr_count = 0;
    while (pending_symbols.size() < InputItems) begin
      kind = $urandom_range(0, 99);
      if (kind < 72) begin
        if ($urandom_range(0, 9) == 0) expr_buf.push_back(dig($urandom_range(1, 9)));
        build_valid(($urandom_range(0, 19) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 8));
      end else if (kind < 86) begin
        n = $urandom_range(1, 6);
        repeat (n) expr_buf.push_back(SymW'($urandom_range(0, 255)));
      end else begin
        build_valid($urandom_range(0, 5));
        case ($urandom_range(0, 2))
          0:       expr_buf.push_back(pick_operator());
          1:       expr_buf.push_front(pick_operator());
          default: expr_buf.push_front(SymTilde);
        endcase
        expr_buf.push_back(dig($urandom_range(1, 9)));
      end
      queue_expr(expr_count % PauseEvery == 0);
      expr_count++;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until everything has been sent and answered, then let the block settle.
    while (pending_symbols.size() > 0 || in_valid) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d symbols in %0d expressions: %0d ok, %0d divide by zero, %0d stack fault",
             symbols_sent, results_checked, status_seen[StOk], status_seen[StDivZero],
             status_seen[StFault]);
    $display("deepest stack %0d, input stalled %0d cycles, longest output hold %0d cycles",
             deepest_stack, input_stall_cycles, longest_output_hold);
    if (failures == 0) begin
      $display("postfix_stack_evaluator regression: pass");
    end else begin
      $display("%0d failures", failures);
      $display("postfix_stack_evaluator regression: fail");
    end
    $finish;
  end

endmodule
